// ----- design/byte_stuff_frame_encoder_top_macros.svh -----
`ifndef BYTE_STUFF_FRAME_ENCODER_TOP_MACROS_SVH
`define BYTE_STUFF_FRAME_ENCODER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BSFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BSFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bsfe_pkg.sv -----
package bsfe_pkg;

    localparam int AddrW    = 5;
    localparam int DataW    = 32;
    localparam int QueueDepth = 2;

    typedef logic [7:0] byte_t;

    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [2:0] {
        REG_START_CODE  = 3'd0,
        REG_END_CODE    = 3'd1,
        REG_ESCAPE_CODE = 3'd2,
        REG_START_SUB   = 3'd3,
        REG_END_SUB     = 3'd4,
        REG_ESCAPE_SUB  = 3'd5,
        REG_CHECK_MODE  = 3'd6
    } reg_idx_t;

    localparam byte_t RST_START_CODE  = 8'd2;
    localparam byte_t RST_END_CODE    = 8'd3;
    localparam byte_t RST_ESCAPE_CODE = 8'd27;
    localparam byte_t RST_START_SUB   = 8'd1;
    localparam byte_t RST_END_SUB     = 8'd2;
    localparam byte_t RST_ESCAPE_SUB  = 8'd3;
    localparam logic  RST_CHECK_MODE  = 1'b1;

    localparam logic CHECK_LRC = 1'b0;
    localparam logic CHECK_CRC = 1'b1;

    typedef struct packed {
        byte_t start_code;
        byte_t end_code;
        byte_t escape_code;
        byte_t start_sub;
        byte_t end_sub;
        byte_t escape_sub;
        logic  check_mode;
    } cfg_t;

    typedef struct packed {
        byte_t       data;
        logic        opens_frame;
        logic        last;
        logic [15:0] crc;
        byte_t       lrc;
    } entry_t;

    typedef enum logic [2:0] {
        PH_BEGIN  = 3'd0,
        PH_START  = 3'd1,
        PH_DATA   = 3'd2,
        PH_CHK_LO = 3'd3,
        PH_CHK_HI = 3'd4,
        PH_END    = 3'd5
    } phase_t;

endpackage

// ----- design/bsfe_ifs.sv -----
interface bsfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bsfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;

    modport source (output valid, output out_byte, output run_last, output frame_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input frame_end,
                    output ready);
endinterface

// ----- design/byte_stuff_frame_encoder_top.sv -----
// Channel  Dir  Words                            Handshake
// in_ch    in   data_byte, last_byte             valid/ready
// out_ch   out  out_byte, run_last, frame_end    valid/ready
// apb      in   7 registers at 4*i               psel/penable, pready tied high
//
// Input is taken whenever the 2-deep queue has room; the front side updates CRC/LRC
// in the accept cycle. The back side emits one line byte per cycle unless out_ch stalls,
// so an input word yields 1 to 8 output bytes (start, data or escape pair, check bytes, end).
// Output is registered; a stalled out_ch holds its word and fills the queue.
// rst_n asynchronously clears frame state, accumulators and queue, and resets registers.
module byte_stuff_frame_encoder_top (
    input  logic                     clk,
    input  logic                     rst_n,
    bsfe_in_if.sink                  in_ch,
    bsfe_out_if.source               out_ch,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [bsfe_pkg::AddrW-1:0] paddr,
    input  logic [bsfe_pkg::DataW-1:0] pwdata,
    output logic [bsfe_pkg::DataW-1:0] prdata,
    output logic                     pready
);
    import bsfe_pkg::*;

    cfg_t   cfg;
    entry_t q_wdata;
    entry_t q_head;
    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_not_empty;

    bsfe_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bsfe_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    bsfe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    bsfe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_not_empty (q_not_empty),
        .head        (q_head),
        .q_pop       (q_pop),
        .out_ch      (out_ch)
    );

endmodule

// ----- design/bsfe_cfg.sv -----
module bsfe_cfg (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [bsfe_pkg::AddrW-1:0] paddr,
    input  logic [bsfe_pkg::DataW-1:0] pwdata,
    output logic [bsfe_pkg::DataW-1:0] prdata,
    output logic                     pready,
    output bsfe_pkg::cfg_t           cfg
);
    import bsfe_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_START_CODE:  cfg_next.start_code  = pwdata[7:0];
                REG_END_CODE:    cfg_next.end_code    = pwdata[7:0];
                REG_ESCAPE_CODE: cfg_next.escape_code = pwdata[7:0];
                REG_START_SUB:   cfg_next.start_sub   = pwdata[7:0];
                REG_END_SUB:     cfg_next.end_sub     = pwdata[7:0];
                REG_ESCAPE_SUB:  cfg_next.escape_sub  = pwdata[7:0];
                REG_CHECK_MODE:  cfg_next.check_mode  = pwdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_START_CODE:  prdata = {{(DataW-8){1'b0}}, cfg_reg.start_code};
            REG_END_CODE:    prdata = {{(DataW-8){1'b0}}, cfg_reg.end_code};
            REG_ESCAPE_CODE: prdata = {{(DataW-8){1'b0}}, cfg_reg.escape_code};
            REG_START_SUB:   prdata = {{(DataW-8){1'b0}}, cfg_reg.start_sub};
            REG_END_SUB:     prdata = {{(DataW-8){1'b0}}, cfg_reg.end_sub};
            REG_ESCAPE_SUB:  prdata = {{(DataW-8){1'b0}}, cfg_reg.escape_sub};
            REG_CHECK_MODE:  prdata = {{(DataW-1){1'b0}}, cfg_reg.check_mode};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_code  <= RST_START_CODE;
            cfg_reg.end_code    <= RST_END_CODE;
            cfg_reg.escape_code <= RST_ESCAPE_CODE;
            cfg_reg.start_sub   <= RST_START_SUB;
            cfg_reg.end_sub     <= RST_END_SUB;
            cfg_reg.escape_sub  <= RST_ESCAPE_SUB;
            cfg_reg.check_mode  <= RST_CHECK_MODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- design/bsfe_front.sv -----
module bsfe_front (
    input  logic              clk,
    input  logic              rst_n,
    bsfe_in_if.sink           in_ch,
    input  logic              q_full,
    output logic              q_push,
    output bsfe_pkg::entry_t  q_wdata
);
    import bsfe_pkg::*;

    logic        in_frame_reg;
    logic        in_frame_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    byte_t       lrc_reg;
    byte_t       lrc_next;
    logic [15:0] crc_upd;
    byte_t       lrc_upd;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input byte_t b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    assign in_ch.ready = !q_full;
    assign q_push      = in_ch.valid && !q_full;
    assign crc_upd     = crc_byte(crc_reg, in_ch.data_byte);
    assign lrc_upd     = lrc_reg ^ in_ch.data_byte;

    always_comb
    begin
        q_wdata.data        = in_ch.data_byte;
        q_wdata.opens_frame = !in_frame_reg;
        q_wdata.last        = in_ch.last_byte;
        q_wdata.crc         = crc_upd;
        q_wdata.lrc         = lrc_upd;
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        crc_next      = crc_reg;
        lrc_next      = lrc_reg;
        if (q_push)
        begin
            in_frame_next = !in_ch.last_byte;
            crc_next      = in_ch.last_byte ? 16'h0000 : crc_upd;
            lrc_next      = in_ch.last_byte ? 8'h00 : lrc_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            crc_reg      <= '0;
            lrc_reg      <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            crc_reg      <= crc_next;
            lrc_reg      <= lrc_next;
        end
    end

endmodule

// ----- design/bsfe_queue.sv -----
module bsfe_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bsfe_pkg::entry_t wdata,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output bsfe_pkg::entry_t head
);
    import bsfe_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);
    localparam int CntW = $clog2(QueueDepth + 1);

    entry_t          slot_reg [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        return (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full      = (count_reg == CntW'(QueueDepth));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- design/bsfe_back.sv -----
module bsfe_back (
    input  logic             clk,
    input  logic             rst_n,
    input  bsfe_pkg::cfg_t   cfg,
    input  logic             q_not_empty,
    input  bsfe_pkg::entry_t head,
    output logic             q_pop,
    bsfe_out_if.source       out_ch
);
    import bsfe_pkg::*;

    phase_t phase_reg;
    phase_t phase_next;
    phase_t cur_ph;
    phase_t step_ph;
    logic   sub_reg;
    logic   sub_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    byte_t  out_byte_reg;
    logic   run_last_reg;
    logic   frame_end_reg;

    byte_t  raw;
    byte_t  subst;
    logic   escapable;
    logic   match;
    logic   emit_esc;
    logic   entry_done;
    logic   load;
    byte_t  emit_byte;
    logic   emit_last;
    logic   emit_end;

    assign load = q_not_empty && (!out_valid_reg || out_ch.ready);

    // decode of the current step
    always_comb
    begin
        cur_ph = phase_reg;
        if (phase_reg == PH_BEGIN)
        begin
            cur_ph = head.opens_frame ? PH_START : PH_DATA;
        end

        unique case (cur_ph)
            PH_START:  raw = cfg.start_code;
            PH_DATA:   raw = head.data;
            PH_CHK_LO: raw = (cfg.check_mode == CHECK_CRC) ? head.crc[7:0] : head.lrc;
            PH_CHK_HI: raw = head.crc[15:8];
            PH_END:    raw = cfg.end_code;
            default:   raw = head.data;
        endcase

        escapable = (cur_ph == PH_DATA) || (cur_ph == PH_CHK_LO) || (cur_ph == PH_CHK_HI);

        if (raw == cfg.start_code)
        begin
            subst = cfg.start_sub;
        end
        else if (raw == cfg.end_code)
        begin
            subst = cfg.end_sub;
        end
        else
        begin
            subst = cfg.escape_sub;
        end
        match = escapable && ((raw == cfg.start_code) || (raw == cfg.end_code)
                              || (raw == cfg.escape_code));

        emit_esc = match && !sub_reg;

        unique case (cur_ph)
            PH_START:  step_ph = PH_DATA;
            PH_DATA:   step_ph = head.last ? PH_CHK_LO : PH_BEGIN;
            PH_CHK_LO: step_ph = (cfg.check_mode == CHECK_CRC) ? PH_CHK_HI : PH_END;
            PH_CHK_HI: step_ph = PH_END;
            PH_END:    step_ph = PH_BEGIN;
            default:   step_ph = PH_BEGIN;
        endcase

        entry_done = !emit_esc && (step_ph == PH_BEGIN);
    end

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        sub_next       = sub_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            phase_next     = emit_esc ? cur_ph : step_ph;
            sub_next       = emit_esc;
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // outputs
    always_comb
    begin
        if (emit_esc)
        begin
            emit_byte = cfg.escape_code;
        end
        else if (sub_reg)
        begin
            emit_byte = subst;
        end
        else
        begin
            emit_byte = raw;
        end
        emit_last = entry_done;
        emit_end  = (cur_ph == PH_END);
        q_pop     = load && entry_done;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_byte  = out_byte_reg;
    assign out_ch.run_last  = run_last_reg;
    assign out_ch.frame_end = frame_end_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= emit_byte;
            run_last_reg  <= emit_last;
            frame_end_reg <= emit_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BEGIN;
            sub_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            sub_reg       <= sub_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- design/bsfe_checker.sv -----
`include "byte_stuff_frame_encoder_top_macros.svh"

module bsfe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       frame_end
);

    // closing end byte is always the final word of its input word
    `BSFE_ASSERT_NOW(a_end_is_last, out_valid && frame_end, run_last, "frame_end without run_last")

    // more words of the same input follow without a bubble
    `BSFE_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !run_last, out_valid, "gap inside an input's output run")

    `BSFE_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(run_last) && $stable(frame_end), "stalled output word changed")

endmodule

bind byte_stuff_frame_encoder_top bsfe_checker u_bsfe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .run_last  (out_ch.run_last),
    .frame_end (out_ch.frame_end)
);

// ----- bench/tb_byte_stuff_frame_encoder_top.sv -----
module tb_byte_stuff_frame_encoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bsfe_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_WORDS = 42;
    localparam int RANDOM_PHASES = 8;

    localparam cfg_t RESET_CFG = '{RST_START_CODE, RST_END_CODE, RST_ESCAPE_CODE,
                                   RST_START_SUB, RST_END_SUB, RST_ESCAPE_SUB,
                                   RST_CHECK_MODE};

    typedef struct packed {
        byte_t data;
        logic  last;
    } raw_word_t;

    typedef struct packed {
        byte_t out_byte;
        logic  run_last;
        logic  frame_end;
    } line_word_t;

    logic clk = 1'b0;
    logic rst_n;

    bsfe_in_if  in_ch();
    bsfe_out_if out_ch();

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [AddrW-1:0]    paddr;
    logic [DataW-1:0]    pwdata;
    logic [DataW-1:0]    prdata;
    logic                pready;

    byte_stuff_frame_encoder_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    // encoder image: line settings and running frame state
    cfg_t        line_cfg;
    logic        frame_open;
    logic [15:0] crc_run;
    byte_t       lrc_run;

    raw_word_t  raw_pending[$];
    line_word_t line_bytes_due[$];
    raw_word_t  nxt_raw;
    line_word_t want_word;

    int   items_queued;
    int   items_taken;
    int   line_bytes_seen;
    int   frames_closed;
    int   settings_applied;
    int   mismatches;
    int   quiet_cycles;
    int   burst_left;
    int   gap_left;
    int   pat_age;
    logic [15:0] stall_pat;
    logic in_took;

    function automatic logic [15:0] crc16_arc_step(logic [15:0] c, byte_t b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic void push_line(byte_t b, logic fe);
        line_word_t w;
        w.out_byte  = b;
        w.run_last  = 1'b0;
        w.frame_end = fe;
        line_bytes_due.push_back(w);
    endfunction

    // start, then end, then escape: first match wins
    function automatic void push_stuffed(byte_t b);
        if (b == line_cfg.start_code)
        begin
            push_line(line_cfg.escape_code, 1'b0);
            push_line(line_cfg.start_sub, 1'b0);
        end
        else if (b == line_cfg.end_code)
        begin
            push_line(line_cfg.escape_code, 1'b0);
            push_line(line_cfg.end_sub, 1'b0);
        end
        else if (b == line_cfg.escape_code)
        begin
            push_line(line_cfg.escape_code, 1'b0);
            push_line(line_cfg.escape_sub, 1'b0);
        end
        else
        begin
            push_line(b, 1'b0);
        end
    endfunction

    function automatic void encode_raw_byte(byte_t b, logic last);
        if (!frame_open)
        begin
            push_line(line_cfg.start_code, 1'b0);
            frame_open = 1'b1;
        end
        crc_run = crc16_arc_step(crc_run, b);
        lrc_run = lrc_run ^ b;
        push_stuffed(b);
        if (last)
        begin
            if (line_cfg.check_mode == CHECK_CRC)
            begin
                push_stuffed(crc_run[7:0]);
                push_stuffed(crc_run[15:8]);
            end
            else
            begin
                push_stuffed(lrc_run);
            end
            push_line(line_cfg.end_code, 1'b1);
            frame_open = 1'b0;
            crc_run = '0;
            lrc_run = '0;
        end
        line_bytes_due[line_bytes_due.size()-1].run_last = 1'b1;
    endfunction

    task automatic flag_mismatch(string what, byte_t got, byte_t want);
        $display("MISMATCH %s: got %02h want %02h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    function automatic void queue_raw(byte_t b, logic last);
        raw_word_t w;
        w.data = b;
        w.last = last;
        raw_pending.push_back(w);
        items_queued++;
    endfunction

    function automatic byte_t draw_raw_byte();
        case ($urandom_range(0, 9))
            0: return line_cfg.start_code;
            1: return line_cfg.end_code;
            2: return line_cfg.escape_code;
            3: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic cfg_t draw_settings();
        cfg_t c;
        c.start_sub  = 8'($urandom);
        c.end_sub    = 8'($urandom);
        c.escape_sub = 8'($urandom);
        case ($urandom_range(0, 4))
            0:
            begin
                c.start_code  = 8'($urandom);
                c.end_code    = 8'($urandom);
                c.escape_code = 8'($urandom);
            end
            1:
            begin
                c.start_code  = 8'($urandom);
                c.end_code    = c.start_code;
                c.escape_code = c.start_code;
            end
            2:
            begin
                c.start_code  = 8'h00;
                c.end_code    = 8'hFF;
                c.escape_code = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            3:
            begin
                c = RESET_CFG;
            end
            default:
            begin
                c.start_code  = 8'($urandom_range(0, 3));
                c.end_code    = 8'($urandom_range(0, 3));
                c.escape_code = 8'($urandom_range(0, 3));
            end
        endcase
        c.check_mode = 1'($urandom_range(0, 1));
        return c;
    endfunction

    task automatic write_reg(reg_idx_t idx, byte_t v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_START_CODE:  line_cfg.start_code  = v;
            REG_END_CODE:    line_cfg.end_code    = v;
            REG_ESCAPE_CODE: line_cfg.escape_code = v;
            REG_START_SUB:   line_cfg.start_sub   = v;
            REG_END_SUB:     line_cfg.end_sub     = v;
            REG_ESCAPE_SUB:  line_cfg.escape_sub  = v;
            REG_CHECK_MODE:  line_cfg.check_mode  = v[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(cfg_t c);
        write_reg(REG_START_CODE, c.start_code);
        write_reg(REG_END_CODE, c.end_code);
        write_reg(REG_ESCAPE_CODE, c.escape_code);
        write_reg(REG_START_SUB, c.start_sub);
        write_reg(REG_END_SUB, c.end_sub);
        write_reg(REG_ESCAPE_SUB, c.escape_sub);
        write_reg(REG_CHECK_MODE, {7'h0, c.check_mode});
        settings_applied++;
    endtask

    // every word yields at least one line byte, so an empty due queue means idle
    task automatic wait_idle(int settle);
        while (items_taken != items_queued || line_bytes_due.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    // sender: bursts with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else if (!in_ch.valid || in_took)
        begin
            if (gap_left > 0 || raw_pending.size() == 0)
            begin
                in_ch.valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
            else
            begin
                nxt_raw = raw_pending.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.data_byte <= nxt_raw.data;
                in_ch.last_byte <= nxt_raw.last;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end
            end
        end
    end

    // receiver: rotating stall pattern, redrawn now and then
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (pat_age <= 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pat = 16'hFFFF;
                    1: stall_pat = 16'($urandom) | 16'h0001;
                    2: stall_pat = 16'($urandom) | 16'($urandom);
                    default: stall_pat = 16'h0007;
                endcase
                pat_age = $urandom_range(40, 200);
            end
            pat_age--;
            out_ch.ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_took <= 1'b0;
        end
        else
        begin
            in_took <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready)
            begin
                encode_raw_byte(in_ch.data_byte, in_ch.last_byte);
                items_taken++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                line_bytes_seen++;
                if (out_ch.frame_end)
                    frames_closed++;
                if (line_bytes_due.size() == 0)
                begin
                    flag_mismatch("unexpected word", out_ch.out_byte, 8'h00);
                end
                else
                begin
                    want_word = line_bytes_due.pop_front();
                    if (out_ch.out_byte !== want_word.out_byte)
                        flag_mismatch("out_byte", out_ch.out_byte, want_word.out_byte);
                    if (out_ch.run_last !== want_word.run_last)
                        flag_mismatch("run_last", {7'h0, out_ch.run_last},
                                      {7'h0, want_word.run_last});
                    if (out_ch.frame_end !== want_word.frame_end)
                        flag_mismatch("frame_end", {7'h0, out_ch.frame_end},
                                      {7'h0, want_word.frame_end});
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("watchdog: no traffic for %0d cycles, %0d line bytes still due",
                     QUIET_LIMIT, line_bytes_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int remaining;
        int flen;
        cfg_t c;

        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        out_ch.ready    = 1'b0;
        line_cfg        = RESET_CFG;
        frame_open      = 1'b0;
        crc_run         = '0;
        lrc_run         = '0;
        items_queued    = 0;
        items_taken     = 0;
        line_bytes_seen = 0;
        frames_closed   = 0;
        settings_applied = 0;
        mismatches      = 0;
        quiet_cycles    = 0;
        burst_left      = 0;
        gap_left        = 0;
        pat_age         = 0;
        stall_pat       = '1;
        in_took         = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings, CRC: every code byte, data extremes, one-byte frame
        queue_raw(8'h02, 1'b0);
        queue_raw(8'h03, 1'b0);
        queue_raw(8'h1B, 1'b0);
        queue_raw(8'h00, 1'b0);
        queue_raw(8'hFF, 1'b1);
        queue_raw(8'h1B, 1'b1);
        wait_idle(4);

        // extreme codes, end and escape overlap, LRC
        apply_settings('{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h80, CHECK_LRC});
        queue_raw(8'h00, 1'b0);
        queue_raw(8'hFF, 1'b0);
        queue_raw(8'h7E, 1'b0);
        queue_raw(8'h81, 1'b1);
        queue_raw(8'h00, 1'b1);
        queue_raw(8'hFF, 1'b1);

        // settings change inside an open frame
        queue_raw(8'h11, 1'b0);
        queue_raw(8'h22, 1'b0);
        wait_idle(4);
        write_reg(REG_ESCAPE_CODE, 8'h22);
        write_reg(REG_CHECK_MODE, {7'h0, CHECK_CRC});
        queue_raw(8'h22, 1'b0);
        queue_raw(8'h33, 1'b1);
        wait_idle(4);

        // all three codes equal: start substitute wins
        apply_settings('{8'h5A, 8'h5A, 8'h5A, 8'hA5, 8'h00, 8'hFF, CHECK_CRC});
        queue_raw(8'h5A, 1'b0);
        queue_raw(8'hA5, 1'b1);
        wait_idle(4);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            c = draw_settings();
            apply_settings(c);
            remaining = PHASE_WORDS;
            while (remaining > 0)
            begin
                flen = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30)
                                                   : $urandom_range(1, 6);
                for (int k = 0; k < flen && remaining > 0; k++)
                begin
                    queue_raw(draw_raw_byte(), k == flen - 1);
                    remaining--;
                end
            end
            wait_idle(4);
        end
        queue_raw(draw_raw_byte(), 1'b1);
        wait_idle(16);

        $display("covered %0d raw bytes, %0d line bytes, %0d frames closed",
                 items_taken, line_bytes_seen, frames_closed);
        $display("over %0d register settings including overlapping and extreme codes",
                 settings_applied + 2);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
